[rtl/gms_pkg.sv]
`default_nettype none

package gms_pkg;

   // remote command codes
   localparam logic [1:0] CMD_NONE         = 2'd0;
   localparam logic [1:0] CMD_TOGGLE_OPEN  = 2'd1;
   localparam logic [1:0] CMD_TOGGLE_CLOSE = 2'd2;
   localparam logic [1:0] CMD_STATUS       = 2'd3;

   // motor drive codes
   localparam logic [1:0] DRIVE_STOP  = 2'd0;
   localparam logic [1:0] DRIVE_LEFT  = 2'd1;
   localparam logic [1:0] DRIVE_RIGHT = 2'd2;

   typedef enum logic [2:0] {
      SCR_NONE      = 3'd0,
      SCR_WAIT      = 3'd1,
      SCR_EMPTY     = 3'd2,
      SCR_OPENED    = 3'd3,
      SCR_CLOSED    = 3'd4,
      SCR_OPEN      = 3'd5,
      SCR_CLOSE     = 3'd6,
      SCR_EMERGENCY = 3'd7
   } screen_type;

   // packed so that open_request lands on bit 0 of the status report
   typedef struct packed {
      logic dir_right;
      logic dir_left;
      logic running;
      logic wait_flag;
      logic press_latch;
      logic close_request;
      logic open_request;
   } flags_type;

   typedef struct packed {
      flags_type flags;
      logic      halt_latch;
   } state_type;

   typedef struct packed {
      logic       emergency;
      logic       presence_1;
      logic       presence_2;
      logic       button_open;
      logic       button_close;
      logic       endstop_open;
      logic       endstop_close;
      logic [1:0] remote_command;
   } req_type;

   typedef struct packed {
      logic [1:0] drive_dir;
      logic       halted;
      screen_type screen;
      logic       report_request;
      logic [6:0] flags_report;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/gms_step.sv]
`default_nettype none

module gms_step (
   input  var gms_pkg::state_type state,
   input  var gms_pkg::req_type   req,
   output var gms_pkg::state_type state_next,
   output var gms_pkg::rsp_type   rsp
);
   import gms_pkg::*;

   flags_type  f;
   screen_type scr;
   logic       halt;
   logic       present;
   logic       report;
   logic [1:0] drive;

   always_comb begin
      f       = state.flags;
      scr     = SCR_NONE;
      report  = 1'b0;
      drive   = DRIVE_STOP;
      halt    = state.halt_latch | req.emergency;
      present = req.presence_1 | req.presence_2;

      if (!halt) begin
         // presence sensors
         if (present && !f.wait_flag) begin
            f.wait_flag = 1'b1;
            scr         = SCR_WAIT;
         end
         if (!present && f.wait_flag) begin
            f.wait_flag = 1'b0;
         end

         // buttons through the press latch
         if (f.open_request && f.close_request) begin
            f.open_request  = 1'b0;
            f.close_request = 1'b0;
         end
         if (!req.button_open && !req.button_close && f.press_latch) begin
            f.press_latch = 1'b0;
         end
         if (req.button_open && !f.press_latch) begin
            f.press_latch  = 1'b1;
            f.open_request = ~f.open_request;
         end
         if (req.button_close && !f.press_latch) begin
            f.press_latch   = 1'b1;
            f.close_request = ~f.close_request;
         end

         // end stops
         if (!req.endstop_open && !req.endstop_close && !f.wait_flag && !f.running) begin
            scr = SCR_EMPTY;
         end
         if (req.endstop_open && !req.endstop_close && !f.wait_flag && !f.running
             && !f.dir_right) begin
            scr = SCR_OPENED;
         end
         if (!req.endstop_open && req.endstop_close && !f.wait_flag && !f.running
             && !f.dir_left) begin
            scr = SCR_CLOSED;
         end
         if (req.endstop_open) begin
            f.open_request = 1'b0;
         end
         if (req.endstop_close) begin
            f.close_request = 1'b0;
         end

         // motor start, pause and stop
         if (f.open_request && !f.wait_flag && !f.running) begin
            f.running   = 1'b1;
            f.dir_left  = 1'b1;
            f.dir_right = 1'b0;
            scr         = SCR_OPEN;
         end
         if (f.close_request && !f.wait_flag && !f.running) begin
            f.running   = 1'b1;
            f.dir_left  = 1'b0;
            f.dir_right = 1'b1;
            scr         = SCR_CLOSE;
         end
         if ((f.open_request || f.close_request) && f.wait_flag && f.running) begin
            f.running = 1'b0;
            scr       = SCR_WAIT;
         end
         if (!f.open_request && !f.close_request && !f.wait_flag && f.running) begin
            f.running   = 1'b0;
            f.dir_left  = 1'b0;
            f.dir_right = 1'b0;
         end
         if (!f.open_request && !f.close_request && f.wait_flag
             && (f.dir_left || f.dir_right)) begin
            f.wait_flag = 1'b0;
            f.running   = 1'b0;
            f.dir_left  = 1'b0;
            f.dir_right = 1'b0;
         end

         // remote command
         unique case (req.remote_command)
            CMD_TOGGLE_OPEN:  f.open_request  = ~f.open_request;
            CMD_TOGGLE_CLOSE: f.close_request = ~f.close_request;
            CMD_STATUS:       report = 1'b1;
            CMD_NONE:         ;
            default:          ;
         endcase

         if (f.running && f.dir_left) begin
            drive = DRIVE_LEFT;
         end else if (f.running && f.dir_right) begin
            drive = DRIVE_RIGHT;
         end
      end else begin
         scr = SCR_EMERGENCY;
      end

      state_next.flags      = f;
      state_next.halt_latch = halt;

      rsp.drive_dir      = drive;
      rsp.halted         = halt;
      rsp.screen         = scr;
      rsp.report_request = report;
      rsp.flags_report   = f;
   end

endmodule

`default_nettype wire

[rtl/gate_motion_sequencer.sv]
// gate motion sequencer: one request is one pass of the gate control loop
//
// req channel: req_item carries the debounced emergency, presence sensor,
//   button and end-stop levels plus a decoded remote command. a request is
//   taken on a rising edge with req_valid high and req_stall low.
// rsp channel: each request gives exactly one rsp_item (drive direction,
//   halt, screen chosen, report request and the flag word after the pass),
//   taken on a rising edge with rsp_valid high and rsp_stall low.
// response: registered, and presented in the cycle after its request is taken.
// throughput: one request per cycle while no response is held by rsp_stall;
//   the whole pass is a single combinational step between the state flops and the response register.
// stall: while a response is held by rsp_stall the response register is
//   full, so req_stall is raised; it drops in the cycle the response goes.
// reset: synchronous, active high; clears all gate flags, the halt latch and
//   the response valid. an emergency halt is only left through reset.
`default_nettype none

module gate_motion_sequencer (
   input  var logic             clock,
   input  var logic             reset,
   input  var logic             req_valid,
   output var logic             req_stall,
   input  var gms_pkg::req_type req_item,
   output var logic             rsp_valid,
   input  var logic             rsp_stall,
   output var gms_pkg::rsp_type rsp_item
);
   import gms_pkg::*;

   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_accept;

   gms_step u_step (
      .state      (state_ff),
      .req        (req_item),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.halt_latch |=> state_ff.halt_latch)
      else $error("halt latch dropped without reset");

   a_halt_drive_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.halted |-> rsp_ff.drive_dir == DRIVE_STOP
                                        && rsp_ff.screen == SCR_EMERGENCY)
      else $error("halted response still drives the motor");

   a_run_has_dir: assert property (@(posedge clock) disable iff (reset)
      state_ff.flags.running |-> (state_ff.flags.dir_left || state_ff.flags.dir_right))
      else $error("running with no direction set");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");
`endif

endmodule

`default_nettype wire
